// ===== rtl/smoothing_decimator_2x_macros.svh =====
// Assertion macros used by the port checker of the smoothing decimator.
`ifndef SMOOTHING_DECIMATOR_2X_MACROS_SVH
`define SMOOTHING_DECIMATOR_2X_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define SDEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdec assertion failed");

// Check cons in the cycle after ante, outside reset.
`define SDEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdec assertion failed");

`endif

// ===== rtl/sdec_pkg.sv =====
// Shared types and constants for the smoothing decimator.
`default_nettype none

package sdec_pkg;

  // Divide-by-four of the 1-2-1 kernel sum
  localparam int unsigned FILTER_SHIFT = 2;

  // Result status for one item leaving the input stage
  typedef struct packed {
    logic emit;
    logic last;
  } sdec_res_t;

endpackage

`default_nettype wire

// ===== rtl/sdec_phase.sv =====
// Phase tracking, sample history and 1-2-1 smoothing of the decimator.
`default_nettype none

module sdec_phase #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           block_end,
  output sdec_pkg::sdec_res_t                 res,
  output logic signed [SAMPLE_WIDTH-1:0]      value
);
  import sdec_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] older_r, older_nxt;
  logic signed [SAMPLE_WIDTH-1:0] newer_r, newer_nxt;
  logic                           odd_phase_r, odd_phase_nxt;
  logic                           at_start_r, at_start_nxt;
  logic signed [SAMPLE_WIDTH+1:0] sum;
  logic signed [SAMPLE_WIDTH+1:0] sum_sh;
  logic signed [SAMPLE_WIDTH-1:0] smooth;

  // Form a + 2b + c at full precision, floor-divide by four
  assign sum = {{2{older_r[SAMPLE_WIDTH-1]}}, older_r}
             + {newer_r[SAMPLE_WIDTH-1], newer_r, 1'b0}
             + {{2{sample[SAMPLE_WIDTH-1]}}, sample};
  assign sum_sh = sum >>> FILTER_SHIFT;
  assign smooth = sum_sh[SAMPLE_WIDTH-1:0];

  // Select the result: even end passes through, odd index releases the pending one
  always_comb begin
    res.emit = odd_phase_r | block_end;
    res.last = block_end;
    if (!odd_phase_r) begin
      value = sample;
    end else if (at_start_r) begin
      value = newer_r;
    end else begin
      value = smooth;
    end
  end

  // Advance the history; a block end returns everything to the start state
  always_comb begin
    older_nxt     = older_r;
    newer_nxt     = newer_r;
    odd_phase_nxt = odd_phase_r;
    at_start_nxt  = at_start_r;
    if (adv) begin
      if (block_end) begin
        older_nxt     = '0;
        newer_nxt     = '0;
        odd_phase_nxt = 1'b0;
        at_start_nxt  = 1'b1;
      end else begin
        older_nxt     = newer_r;
        newer_nxt     = sample;
        odd_phase_nxt = ~odd_phase_r;
        if (odd_phase_r) begin
          at_start_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r     <= '0;
      newer_r     <= '0;
      odd_phase_r <= 1'b0;
      at_start_r  <= 1'b1;
    end else begin
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      odd_phase_r <= odd_phase_nxt;
      at_start_r  <= at_start_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/smoothing_decimator_2x.sv =====
// Smoothing decimator top level: input register, filter and output register.
//
// Takes one signed sample per item, with block_end on a block's last sample,
// and returns every even-indexed sample smoothed by the 1/4, 1/2, 1/4 kernel
// (floor of (a+2b+c)/4, never overflows); a block's first sample, and its
// last if at an even index, pass unfiltered, and the block's final result
// carries out_last. An item is accepted every cycle while out_stall is low;
// a result is released by the odd-indexed sample after an even one, or by
// the block's last sample, into the output register. The rate is set by
// the output register: when it holds an unread result, an item that would
// produce a new result waits in the input register and in_stall rises.
`default_nettype none

module smoothing_decimator_2x #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  wire logic                           in_block_end,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_out,
  output logic                                out_last
);
  import sdec_pkg::*;

  logic                           s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                           s1_end_r;
  logic                           s1_adv;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_last_r;
  sdec_res_t                      res;
  logic signed [SAMPLE_WIDTH-1:0] value;

  sdec_phase #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (s1_adv),
    .sample   (s1_sample_r),
    .block_end(s1_end_r),
    .res      (res),
    .value    (value)
  );

  // Advance the held item unless it has a result and the output is blocked
  assign s1_adv   = s1_valid_r & (~out_valid_r | ~out_stall | ~res.emit);
  assign in_stall = s1_valid_r & ~s1_adv;

  // Input register: take an item whenever the stage is free or moving on
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample_r <= in_sample_in;
      s1_end_r    <= in_block_end;
    end
  end

  // Output register: load a new result, drop a taken one, hold while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_sample_r <= value;
      out_last_r   <= res.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/sdec_checker.sv =====
// Port-level checks of the smoothing decimator, bound to its top level.
`default_nettype none

`include "smoothing_decimator_2x_macros.svh"

module sdec_port_checks #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           in_block_end,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input wire logic                           out_last
);

  logic out_held;
  logic in_end_taken;

  assign out_held     = out_valid && out_stall;
  assign in_end_taken = in_valid && !in_stall && in_block_end;

  // A stalled result holds until taken
  `SDEC_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable({out_sample_out, out_last}))

  // Input only backs up when the output side is stalled
  `SDEC_ASSERT_NOW(a_no_stall_free, !out_stall, !in_stall)

  // A block end taken with a free output shows up as a final result once it reaches the output register
  `SDEC_ASSERT_NEXT(a_end_last, in_end_taken ##1 !out_stall, out_valid && out_last)

endmodule

bind smoothing_decimator_2x sdec_port_checks #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sdec_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_block_end  (in_block_end),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sample_out(out_sample_out),
  .out_last      (out_last)
);

`default_nettype wire

// ===== verif/sdec_checker.sv =====
// Checker for the smoothing decimator: predicts results from accepted samples and compares.
`timescale 1ns / 1ps

module sdec_checker #(
  parameter int unsigned W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic signed [W-1:0] in_sample_in,
  input  logic                in_block_end,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [W-1:0] out_sample_out,
  input  logic                out_last,
  output int                  error_count,
  output int                  pending,
  output int                  checked_count
);

  typedef struct {
    logic signed [W-1:0] sample;
    logic                last;
  } decim_result_t;

  // Expected decimated samples, oldest first
  decim_result_t decim_q[$];

  // Predictor state: two most recent samples and the position within the block
  logic signed [W-1:0] older_s;
  logic signed [W-1:0] newer_s;
  logic                odd_idx;
  logic                blk_start;

  initial begin
    error_count   = 0;
    pending       = 0;
    checked_count = 0;
  end

  // Floor of (a + 2b + c) / 4 at full precision
  function automatic logic signed [W-1:0] binomial_avg(input logic signed [W-1:0] a,
                                                       input logic signed [W-1:0] b,
                                                       input logic signed [W-1:0] c);
    logic [W+1:0] acc;
    acc = {{2{a[W-1]}}, a} + {b[W-1], b, 1'b0} + {{2{c[W-1]}}, c};
    return acc[W+1:2];
  endfunction

  task automatic report_mismatch(input string what);
    $display("sdec_checker: %s (at %0t)", what, $time);
    error_count++;
  endtask

  task automatic clear_phase();
    older_s   = '0;
    newer_s   = '0;
    odd_idx   = 1'b0;
    blk_start = 1'b1;
  endtask

  task automatic push_result(input logic signed [W-1:0] s, input logic last);
    decim_result_t r;
    r.sample = s;
    r.last   = last;
    decim_q.push_back(r);
  endtask

  always @(posedge clk) begin
    decim_result_t exp_r;
    if (!rst_n) begin
      decim_q.delete();
      clear_phase();
    end else begin
      // Compare an accepted result with the oldest expectation
      if (out_valid && !out_stall) begin
        if (decim_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result sample=%0d last=%0b",
                                    out_sample_out, out_last));
        end else begin
          exp_r = decim_q.pop_front();
          checked_count++;
          if (out_sample_out !== exp_r.sample)
            report_mismatch($sformatf("sample_out got %0d, want %0d",
                                      out_sample_out, exp_r.sample));
          if (out_last !== exp_r.last)
            report_mismatch($sformatf("out_last got %0b, want %0b",
                                      out_last, exp_r.last));
        end
      end
      // Advance the predictor on an accepted item
      if (in_valid && !in_stall) begin
        if (!odd_idx) begin
          if (in_block_end) begin
            push_result(in_sample_in, 1'b1);
            clear_phase();
          end else begin
            older_s = newer_s;
            newer_s = in_sample_in;
            odd_idx = 1'b1;
          end
        end else begin
          // Release the pending even-indexed result; index zero goes out raw
          if (blk_start)
            push_result(newer_s, in_block_end);
          else
            push_result(binomial_avg(older_s, newer_s, in_sample_in), in_block_end);
          if (in_block_end) begin
            clear_phase();
          end else begin
            older_s   = newer_s;
            newer_s   = in_sample_in;
            odd_idx   = 1'b0;
            blk_start = 1'b0;
          end
        end
      end
    end
    pending = decim_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the smoothing decimator: clock, reset, stimulus, pressure and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SW        = 16;
  localparam int          QUIET_MAX = 3000;
  localparam int          PHASE_LEN = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SW-1:0] in_sample_in = '0;
  logic                 in_block_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SW-1:0] out_sample_out;
  logic                 out_last;

  int error_count;
  int pending;
  int checked_count;

  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_off = 1'b0;
  int items_sent = 0;
  int blocks_sent = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  smoothing_decimator_2x #(
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .in_block_end  (in_block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_last      (out_last)
  );

  sdec_checker #(
    .W(SW)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .in_block_end  (in_block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_last      (out_last),
    .error_count   (error_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  // Stall the result channel at random, or hard during a hold-off
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Hold off the receiver for a long stretch while the sender keeps offering
  initial begin
    wait (items_sent >= 100);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("tb_top: timeout after %0d quiet cycles", quiet_cycles);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_sample(input logic signed [SW-1:0] s, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_block_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (last) blocks_sent++;
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    int r;
    logic [31:0] rnd;
    r = $urandom_range(99);
    rnd = $urandom();
    if (r < 4) return 16'sh7fff;
    if (r < 8) return 16'sh8000;
    if (r < 11) return '0;
    if (r < 14) return '1;
    return rnd[SW-1:0];
  endfunction

  task automatic send_random_block();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 10) len = 1;
    else if (r < 20) len = 2;
    else if (r < 85) len = $urandom_range(16, 3);
    else len = $urandom_range(48, 17);
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(), i == len - 1);
  endtask

  initial begin
    int phase_end;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-sample blocks at both extremes
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    // Two samples: index zero released raw by an odd block end
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // Three samples: block ends on an even index
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // Full-scale positive run, filtered middle sample stays in range
    for (int i = 0; i < 5; i++) send_sample(16'sh7fff, i == 4);
    // Alternating small values, odd block end
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    // Negative sum that must round toward minus infinity
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);

    // Random blocks across the idle and stall phases
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 71;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 71;
        end
        default: begin
          idle_pct = 37;
          stall_pct <= 37;
        end
      endcase
      phase_end = items_sent + PHASE_LEN;
      while (items_sent < phase_end) send_random_block();
    end
    in_valid <= 1'b0;

    // Drain the remaining results, then let the pipeline settle
    wait (pending == 0);
    repeat (8) @(posedge clk);

    $display("tb_top: %0d samples in %0d blocks sent, %0d decimated results checked",
             items_sent, blocks_sent, checked_count);
    $display("tb_top: covered edge blocks, full-scale sums, idle/stall phases, long hold-off");
    if (error_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sdec_pkg.sv
rtl/sdec_phase.sv
rtl/smoothing_decimator_2x.sv
rtl/sdec_checker.sv
verif/sdec_checker.sv
verif/tb_top.sv
